### sv/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants of the rectangle split block: piece kinds,
// the piece record and the queue entry that runs from front to back.
// ----------------------------------------------------------------------------
package rsp_pkg;

  // number of pieces one item can produce
  localparam int unsigned NumPieces = 4;

  // depth of the entry queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // piece kind, in emission order
  typedef enum logic [1:0] {
    KindTop    = 2'd0,
    KindBottom = 2'd1,
    KindLeft   = 2'd2,
    KindRight  = 2'd3
  } kind_e;

  // one piece, coordinates and sizes wrapped to 17 bits
  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] w;
    logic signed [16:0] h;
  } piece_t;

  // one classified item: which pieces qualify, and all four pieces
  typedef struct packed {
    logic [NumPieces-1:0]          mask;
    piece_t [NumPieces-1:0]        pc;
  } entry_t;

endpackage

### sv/rect_split_pieces_core.sv
// ----------------------------------------------------------------------------
// rect_split_pieces_core
// Splits a subject rectangle against a cutter rectangle into up to four
// pieces (top, bottom, left, right) and streams them out as results.
// ----------------------------------------------------------------------------
// Each transaction in carries two rectangles and yields one to four result
// transactions: the qualifying pieces in the order top, bottom, left, right,
// or a single empty result when the rectangles do not touch or no piece has
// positive width and height; last_piece_o marks the final one. The block
// keeps no state between items. An item is taken every cycle while the
// result side keeps up; the back end emits one result per cycle while pop is
// held, so the sustained item rate is set by the number of results per item
// (one to four) and the single result port of the back-end serialiser. The
// first result of an item passes the input register, classification into a
// two-entry queue, then the back-end entry register.
module rect_split_pieces_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic signed [15:0]  subject_x_i,
  input  logic signed [15:0]  subject_y_i,
  input  logic signed [15:0]  subject_w_i,
  input  logic signed [15:0]  subject_h_i,
  input  logic signed [15:0]  cutter_x_i,
  input  logic signed [15:0]  cutter_y_i,
  input  logic signed [15:0]  cutter_w_i,
  input  logic signed [15:0]  cutter_h_i,
  output logic                empty,
  input  logic                pop,
  output logic                piece_present_o,
  output logic [1:0]          piece_kind_o,
  output logic signed [16:0]  piece_x_o,
  output logic signed [16:0]  piece_y_o,
  output logic signed [16:0]  piece_w_o,
  output logic signed [16:0]  piece_h_o,
  output logic                last_piece_o
);

  logic             q_push, q_full, q_pop, q_empty;
  rsp_pkg::entry_t  q_wr_entry, q_rd_entry;

  // front end: register and classify
  rsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .subject_x_i (subject_x_i),
    .subject_y_i (subject_y_i),
    .subject_w_i (subject_w_i),
    .subject_h_i (subject_h_i),
    .cutter_x_i  (cutter_x_i),
    .cutter_y_i  (cutter_y_i),
    .cutter_w_i  (cutter_w_i),
    .cutter_h_i  (cutter_h_i),
    .q_push_o    (q_push),
    .q_entry_o   (q_wr_entry),
    .q_full_i    (q_full)
  );

  // entry queue
  rsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .empty_o (q_empty)
  );

  // back end: stream pieces
  rsp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_entry_i       (q_rd_entry),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .piece_present_o (piece_present_o),
    .piece_kind_o    (piece_kind_o),
    .piece_x_o       (piece_x_o),
    .piece_y_o       (piece_y_o),
    .piece_w_o       (piece_w_o),
    .piece_h_o       (piece_h_o),
    .last_piece_o    (last_piece_o)
  );

  // no write into a full queue
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("entry queue written while full");

  // no read from an empty queue
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("entry queue read while empty");

  // an empty result always closes its item
  a_empty_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !piece_present_o) |-> last_piece_o)
    else $error("empty result not marked last");

  // after a non-final result the item still has a result waiting
  a_item_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_piece_o) |=> !empty)
    else $error("item ended without a final result");

endmodule

### sv/rsp_front.sv
// ----------------------------------------------------------------------------
// rsp_front
// Front end: registers the incoming rectangles with their far edges, then
// runs the contact test and forms the four pieces and their qualify mask.
// ----------------------------------------------------------------------------
module rsp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic signed [15:0]   subject_x_i,
  input  logic signed [15:0]   subject_y_i,
  input  logic signed [15:0]   subject_w_i,
  input  logic signed [15:0]   subject_h_i,
  input  logic signed [15:0]   cutter_x_i,
  input  logic signed [15:0]   cutter_y_i,
  input  logic signed [15:0]   cutter_w_i,
  input  logic signed [15:0]   cutter_h_i,
  output logic                 q_push_o,
  output rsp_pkg::entry_t      q_entry_o,
  input  logic                 q_full_i
);

  logic                valid_q;
  logic                load;
  logic signed [15:0]  sx_q, sy_q, sw_q, cx_q, cy_q, cw_q;
  logic signed [16:0]  sr_q, sb_q, cr_q, cb_q;

  // stage register hands over to the queue as soon as it has room
  assign q_push_o = valid_q && !q_full_i;
  assign full_o   = valid_q && q_full_i;
  assign load     = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (q_push_o) begin
      valid_q <= 1'b0;
    end
  end

  // input register with right and bottom edges
  always_ff @(posedge clk_i) begin
    if (load) begin
      sx_q <= subject_x_i;
      sy_q <= subject_y_i;
      sw_q <= subject_w_i;
      cx_q <= cutter_x_i;
      cy_q <= cutter_y_i;
      cw_q <= cutter_w_i;
      sr_q <= 17'(subject_x_i) + 17'(subject_w_i);
      sb_q <= 17'(subject_y_i) + 17'(subject_h_i);
      cr_q <= 17'(cutter_x_i) + 17'(cutter_w_i);
      cb_q <= 17'(cutter_y_i) + 17'(cutter_h_i);
    end
  end

  logic                contact;
  logic                top_sel, bot_sel, left_sel;
  logic signed [15:0]  top_x, top_y, top_w;
  logic signed [16:0]  top_h;
  logic signed [15:0]  bot_x, bot_w;
  logic signed [16:0]  bot_y;
  logic signed [17:0]  bot_h;
  logic signed [15:0]  left_x, left_y, right_x;
  logic signed [16:0]  left_w, max_r;
  logic signed [17:0]  left_h, right_w;

  // contact test on closed extents
  assign contact = (17'(sx_q) <= cr_q) && (17'(cx_q) <= sr_q) &&
                   (17'(sy_q) <= cb_q) && (17'(cy_q) <= sb_q);

  // top piece
  assign top_sel = cy_q > sy_q;
  assign top_x   = top_sel ? sx_q : cx_q;
  assign top_y   = top_sel ? sy_q : cy_q;
  assign top_w   = top_sel ? sw_q : cw_q;
  assign top_h   = top_sel ? (17'(cy_q) - 17'(sy_q)) : (17'(sy_q) - 17'(cy_q));

  // bottom piece
  assign bot_sel = cb_q > sb_q;
  assign bot_x   = bot_sel ? cx_q : sx_q;
  assign bot_y   = bot_sel ? sb_q : cb_q;
  assign bot_w   = bot_sel ? cw_q : sw_q;
  assign bot_h   = bot_sel ? (18'(cb_q) - 18'(sb_q)) : (18'(sb_q) - 18'(cb_q));

  // left piece, from the top piece's bottom edge down to the bottom piece's top edge
  assign left_sel = cx_q > sx_q;
  assign left_x   = left_sel ? sx_q : cx_q;
  assign left_w   = left_sel ? (17'(cx_q) - 17'(sx_q)) : (17'(sx_q) - 17'(cx_q));
  assign left_y   = top_sel ? cy_q : sy_q;
  assign left_h   = 18'(bot_y) - 18'(left_y);

  // right piece starts where the left one ends, the larger left edge
  assign right_x = left_sel ? cx_q : sx_q;
  assign max_r   = (sr_q > cr_q) ? sr_q : cr_q;
  assign right_w = 18'(max_r) - 18'(right_x);

  // queue entry
  always_comb begin
    q_entry_o = '0;
    q_entry_o.mask[rsp_pkg::KindTop]    = contact && (top_w > 0) && (top_h > 0);
    q_entry_o.mask[rsp_pkg::KindBottom] = contact && (bot_w > 0) && (bot_h > 0);
    q_entry_o.mask[rsp_pkg::KindLeft]   = contact && (left_w > 0) && (left_h > 0);
    q_entry_o.mask[rsp_pkg::KindRight]  = contact && (right_w > 0) && (left_h > 0);

    q_entry_o.pc[rsp_pkg::KindTop].x    = 17'(top_x);
    q_entry_o.pc[rsp_pkg::KindTop].y    = 17'(top_y);
    q_entry_o.pc[rsp_pkg::KindTop].w    = 17'(top_w);
    q_entry_o.pc[rsp_pkg::KindTop].h    = top_h;

    q_entry_o.pc[rsp_pkg::KindBottom].x = 17'(bot_x);
    q_entry_o.pc[rsp_pkg::KindBottom].y = bot_y;
    q_entry_o.pc[rsp_pkg::KindBottom].w = 17'(bot_w);
    q_entry_o.pc[rsp_pkg::KindBottom].h = bot_h[16:0];

    q_entry_o.pc[rsp_pkg::KindLeft].x   = 17'(left_x);
    q_entry_o.pc[rsp_pkg::KindLeft].y   = 17'(left_y);
    q_entry_o.pc[rsp_pkg::KindLeft].w   = left_w;
    q_entry_o.pc[rsp_pkg::KindLeft].h   = left_h[16:0];

    q_entry_o.pc[rsp_pkg::KindRight].x  = 17'(right_x);
    q_entry_o.pc[rsp_pkg::KindRight].y  = 17'(left_y);
    q_entry_o.pc[rsp_pkg::KindRight].w  = right_w[16:0];
    q_entry_o.pc[rsp_pkg::KindRight].h  = left_h[16:0];
  end

endmodule

### sv/rsp_queue.sv
// ----------------------------------------------------------------------------
// rsp_queue
// Short register queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module rsp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rsp_pkg::entry_t  entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output rsp_pkg::entry_t  entry_o,
  output logic             empty_o
);

  rsp_pkg::entry_t                  mem_q [rsp_pkg::QDepth];
  logic [rsp_pkg::QPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [rsp_pkg::QCntW-1:0]        cnt_q;

  assign full_o  = (cnt_q == rsp_pkg::QCntW'(rsp_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  // next pointer with wrap at the queue depth
  function automatic logic [rsp_pkg::QPtrW-1:0] ptr_next(
    input logic [rsp_pkg::QPtrW-1:0] p
  );
    logic [rsp_pkg::QPtrW-1:0] r;
    if (p == rsp_pkg::QPtrW'(rsp_pkg::QDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### sv/rsp_back.sv
// ----------------------------------------------------------------------------
// rsp_back
// Back end: holds one classified entry and streams its qualifying pieces,
// top first, one per transaction; an entry with none gives one empty result.
// ----------------------------------------------------------------------------
module rsp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsp_pkg::entry_t     q_entry_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic                piece_present_o,
  output logic [1:0]          piece_kind_o,
  output logic signed [16:0]  piece_x_o,
  output logic signed [16:0]  piece_y_o,
  output logic signed [16:0]  piece_w_o,
  output logic signed [16:0]  piece_h_o,
  output logic                last_piece_o
);

  logic                              valid_q;
  logic                              none_q;
  logic [rsp_pkg::NumPieces-1:0]     rem_q;
  rsp_pkg::piece_t [rsp_pkg::NumPieces-1:0] pc_q;

  rsp_pkg::kind_e                    sel;
  logic                              last;
  logic                              take;

  // oldest remaining piece
  always_comb begin
    priority if (rem_q[rsp_pkg::KindTop]) begin
      sel = rsp_pkg::KindTop;
    end else if (rem_q[rsp_pkg::KindBottom]) begin
      sel = rsp_pkg::KindBottom;
    end else if (rem_q[rsp_pkg::KindLeft]) begin
      sel = rsp_pkg::KindLeft;
    end else begin
      sel = rsp_pkg::KindRight;
    end
  end

  assign last    = none_q || ((rem_q & (rem_q - 1'b1)) == '0);
  assign take    = pop_i && valid_q;
  assign q_pop_o = !q_empty_i && (!valid_q || (take && last));

  // entry register and remaining-piece mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      none_q  <= 1'b0;
      rem_q   <= '0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
      none_q  <= (q_entry_i.mask == '0);
      rem_q   <= q_entry_i.mask;
    end else if (take) begin
      if (last) begin
        valid_q <= 1'b0;
      end
      rem_q[sel] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pc_q <= q_entry_i.pc;
    end
  end

  // result ports
  assign empty_o         = !valid_q;
  assign piece_present_o = !none_q;
  assign piece_kind_o    = none_q ? 2'(rsp_pkg::KindTop) : 2'(sel);
  assign piece_x_o       = none_q ? '0 : pc_q[sel].x;
  assign piece_y_o       = none_q ? '0 : pc_q[sel].y;
  assign piece_w_o       = none_q ? '0 : pc_q[sel].w;
  assign piece_h_o       = none_q ? '0 : pc_q[sel].h;
  assign last_piece_o    = last;

endmodule
